// ===== rtl/core/pbu_pkg.sv =====
// package for the packbits bitplane unpacker
// picture geometry constants, pointer unit opcodes and shared types
// no dependencies
package pbu_pkg;

    localparam int LINES            = 200;
    localparam int PLANE_LINE_BYTES = 40;
    localparam int PLANES           = 4;
    localparam int BITMAP_BYTES     = 32768;

    localparam int ADDR_W       = $clog2(BITMAP_BYTES);
    localparam int LINE_STRIDE  = 4 * PLANE_LINE_BYTES;
    localparam int BACK_STEP    = LINE_STRIDE - 2;
    localparam int FWD_STEP     = LINE_STRIDE - 2 * PLANES;
    localparam int HEADER_BYTES = 33;

    localparam logic [7:0] TYPE_PACKED = 8'h80;

    // pointer unit opcodes
    localparam logic [2:0] PTR_NOP  = 3'd0;
    localparam logic [2:0] PTR_STEP = 3'd1;
    localparam logic [2:0] PTR_BACK = 3'd2;
    localparam logic [2:0] PTR_FWD  = 3'd3;
    localparam logic [2:0] PTR_INC  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
    } t_ptr_ctl;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last;
        logic              done;
        logic              err;
    } t_wr;

endpackage

// ===== rtl/core/pbu_ptr_unit.sv =====
// shared write pointer adder: interleave step, plane back step, line forward step
// and raw increment all go through one adder
// depends on pbu_pkg
module pbu_ptr_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pbu_pkg::t_ptr_ctl         i_ctl,
    output logic [pbu_pkg::ADDR_W-1:0] o_ptr
);

    logic [pbu_pkg::ADDR_W-1:0] r_ptr;
    logic [pbu_pkg::ADDR_W-1:0] n_ptr;
    logic                       r_odd;
    logic                       n_odd;
    logic [pbu_pkg::ADDR_W-1:0] w_delta;

    always_comb begin
        w_delta = '0;
        n_odd   = r_odd;
        case (i_ctl.op)
            pbu_pkg::PTR_STEP: begin
                w_delta = r_odd ? pbu_pkg::ADDR_W'(7) : pbu_pkg::ADDR_W'(1);
                n_odd   = ~r_odd;
            end
            pbu_pkg::PTR_BACK: w_delta =
                pbu_pkg::ADDR_W'(pbu_pkg::BITMAP_BYTES - pbu_pkg::BACK_STEP);
            pbu_pkg::PTR_FWD:  w_delta = pbu_pkg::ADDR_W'(pbu_pkg::FWD_STEP);
            pbu_pkg::PTR_INC:  w_delta = pbu_pkg::ADDR_W'(1);
            default:           w_delta = '0;
        endcase
        n_ptr = r_ptr + w_delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_odd <= 1'b0;
        end else begin
            r_ptr <= n_ptr;
            r_odd <= n_odd;
        end
    end

    assign o_ptr = r_ptr;

endmodule

// ===== rtl/core/pbu_out_reg.sv =====
// output register for bitmap write requests
// holds one request until the sink takes it
// depends on pbu_pkg
module pbu_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  pbu_pkg::t_wr  i_wr,
    output logic          o_free,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [23:0]   o_m_tdata,
    output logic          o_m_tlast,
    output logic [1:0]    o_m_tuser
);

    logic         r_valid;
    pbu_pkg::t_wr r_wr;

    assign o_free = ~r_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_wr <= i_wr;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_wr.data, r_wr.addr};
    assign o_m_tlast  = r_wr.last;
    assign o_m_tuser  = {r_wr.err, r_wr.done};

endmodule

// ===== rtl/core/packbits_bitplane_unpacker_unit.sv =====
// packbits bitplane picture unpacker, top level with the byte sequencer
// header, control and dropped bytes cause no write; a data byte is accepted and then
// held in the emit state until each write it causes is loaded; a write that fills a plane line
// adds a back step, and at the end of a line of planes a forward step, through the shared adder
// the emit state loads each write into the output register and waits while it is full
// synchronous active-low reset returns to waiting for the type byte and clears control state
module packbits_bitplane_unpacker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // write_address[14:0], write_data[22:15], zero[23]
    output logic        o_m_tlast,   // run_last
    output logic [1:0]  o_m_tuser    // picture_done[0], format_error[1]
);

    localparam logic [3:0] S_TYPE = 4'd0;
    localparam logic [3:0] S_SKIP = 4'd1;
    localparam logic [3:0] S_CTRL = 4'd2;
    localparam logic [3:0] S_RUNB = 4'd3;
    localparam logic [3:0] S_LIT  = 4'd4;
    localparam logic [3:0] S_DROP = 4'd5;
    localparam logic [3:0] S_RAW  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_BACK = 4'd9;
    localparam logic [3:0] S_FWD  = 4'd10;

    localparam logic [1:0] KIND_RUN = 2'd0;
    localparam logic [1:0] KIND_LIT = 2'd1;
    localparam logic [1:0] KIND_RAW = 2'd2;

    logic [3:0] r_state, n_state;
    logic [5:0] r_hdr, n_hdr;
    logic       r_packed, n_packed;
    logic [7:0] r_pend, n_pend;
    logic [5:0] r_off, n_off;
    logic [1:0] r_plane, n_plane;
    logic [7:0] r_line, n_line;
    logic       r_err, n_err;
    logic [7:0] r_data, n_data;
    logic [1:0] r_kind, n_kind;

    logic                        w_accept;
    logic                        w_free;
    logic                        w_load;
    pbu_pkg::t_wr                w_wr;
    pbu_pkg::t_ptr_ctl           w_ptr_ctl;
    logic [pbu_pkg::ADDR_W-1:0]  w_ptr;
    logic [8:0]                  w_left;
    logic [8:0]                  w_run_cnt;
    logic [8:0]                  w_lit_cnt;
    logic                        w_line_full;
    logic                        w_pic_end;
    logic                        w_raw_end;

    assign o_s_tready = ~r_state[3];
    assign w_accept   = i_s_tvalid & o_s_tready;

    assign w_left    = 9'(pbu_pkg::PLANE_LINE_BYTES) - {3'b000, r_off};
    assign w_run_cnt = 9'd257 - {1'b0, i_s_tdata};
    assign w_lit_cnt = {1'b0, i_s_tdata} + 9'd1;

    assign w_line_full = (r_off == 6'(pbu_pkg::PLANE_LINE_BYTES - 1));
    assign w_pic_end   = w_line_full && (r_plane == 2'(pbu_pkg::PLANES - 1))
                         && (r_line == 8'(pbu_pkg::LINES - 1));
    assign w_raw_end   = (w_ptr == pbu_pkg::ADDR_W'(pbu_pkg::BITMAP_BYTES - 1));

    always_comb begin
        w_wr.addr = w_ptr;
        w_wr.data = r_data;
        w_wr.last = (r_kind != KIND_RUN) || (r_pend == 8'd1);
        w_wr.done = (r_kind == KIND_RAW) ? w_raw_end : w_pic_end;
        w_wr.err  = r_err;
    end

    always_comb begin
        n_state = r_state;
        n_hdr    = r_hdr;
        n_packed = r_packed;
        n_pend   = r_pend;
        n_off    = r_off;
        n_plane  = r_plane;
        n_line   = r_line;
        n_err    = r_err;
        n_data   = r_data;
        n_kind   = r_kind;
        w_load   = 1'b0;
        w_ptr_ctl.op = pbu_pkg::PTR_NOP;
        case (r_state)
            S_TYPE: if (w_accept) begin
                n_packed = (i_s_tdata == pbu_pkg::TYPE_PACKED);
                n_hdr    = 6'(pbu_pkg::HEADER_BYTES);
                n_state  = S_SKIP;
            end
            S_SKIP: if (w_accept) begin
                n_hdr = r_hdr - 6'd1;
                if (r_hdr == 6'd1) begin
                    n_state = r_packed ? S_CTRL : S_RAW;
                end
            end
            S_CTRL: if (w_accept) begin
                if (i_s_tdata[7]) begin
                    if (w_run_cnt > w_left) begin
                        n_pend = w_left[7:0];
                        n_err  = 1'b1;
                    end else begin
                        n_pend = w_run_cnt[7:0];
                    end
                    n_state = S_RUNB;
                end else begin
                    if (w_lit_cnt > w_left) begin
                        n_err = 1'b1;
                    end
                    n_pend  = w_lit_cnt[7:0];
                    n_state = S_LIT;
                end
            end
            S_RUNB: if (w_accept) begin
                n_data  = i_s_tdata;
                n_kind  = KIND_RUN;
                n_state = S_EMIT;
            end
            S_LIT: if (w_accept) begin
                n_data  = i_s_tdata;
                n_kind  = KIND_LIT;
                n_state = S_EMIT;
            end
            S_DROP: if (w_accept) begin
                n_pend = r_pend - 8'd1;
                if (r_pend == 8'd1) begin
                    n_state = S_CTRL;
                end
            end
            S_RAW: if (w_accept) begin
                n_data  = i_s_tdata;
                n_kind  = KIND_RAW;
                n_state = S_EMIT;
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            S_EMIT: if (w_free) begin
                w_load = 1'b1;
                if (r_kind == KIND_RAW) begin
                    w_ptr_ctl.op = pbu_pkg::PTR_INC;
                    n_state      = w_raw_end ? S_DONE : S_RAW;
                end else begin
                    w_ptr_ctl.op = pbu_pkg::PTR_STEP;
                    n_pend       = r_pend - 8'd1;
                    if (w_line_full) begin
                        n_off   = '0;
                        n_state = S_BACK;
                    end else begin
                        n_off = r_off + 6'd1;
                        if (r_kind == KIND_LIT) begin
                            n_state = (r_pend == 8'd1) ? S_CTRL : S_LIT;
                        end else if (r_pend == 8'd1) begin
                            n_state = S_CTRL;
                        end
                    end
                end
            end
            S_BACK: begin
                w_ptr_ctl.op = pbu_pkg::PTR_BACK;
                if (r_plane == 2'(pbu_pkg::PLANES - 1)) begin
                    n_plane = '0;
                    n_line  = r_line + 8'd1;
                    n_state = S_FWD;
                end else begin
                    n_plane = r_plane + 2'd1;
                    n_state = (r_pend == 8'd0) ? S_CTRL : S_DROP;
                end
            end
            S_FWD: begin
                w_ptr_ctl.op = pbu_pkg::PTR_FWD;
                if (r_line == 8'(pbu_pkg::LINES)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (r_pend == 8'd0) ? S_CTRL : S_DROP;
                end
            end
            default: n_state = S_TYPE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_TYPE;
            r_hdr    <= '0;
            r_packed <= 1'b0;
            r_pend   <= '0;
            r_off    <= '0;
            r_plane  <= '0;
            r_line   <= '0;
            r_err    <= 1'b0;
            r_kind   <= KIND_RUN;
        end else begin
            r_state  <= n_state;
            r_hdr    <= n_hdr;
            r_packed <= n_packed;
            r_pend   <= n_pend;
            r_off    <= n_off;
            r_plane  <= n_plane;
            r_line   <= n_line;
            r_err    <= n_err;
            r_kind   <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    pbu_ptr_unit u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ptr_ctl),
        .o_ptr   (w_ptr)
    );

    pbu_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_wr       (w_wr),
        .o_free     (w_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef NO_ASSERTIONS
    // nothing is written after the request that completes the picture
    a_done_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser[0] |=> !o_m_tvalid)
        else $error("write request after picture completion");

    // a planar packet in flight always has writes left
    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (r_kind != KIND_RAW) |-> (r_pend != 8'd0))
        else $error("emitting with no pending writes");

    // the format error flag never clears until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("format error flag cleared");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for packbits_bitplane_unpacker_unit: one packed picture stream with clean
// and malformed packets; carries its own bitplane write predictor; depends on pbu_pkg

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 200;

    typedef enum logic [2:0] {
        ST_TYPE, ST_SKIP, ST_CTRL, ST_RUN, ST_LIT, ST_DROP, ST_RAW, ST_DONE
    } t_parse_st;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // in_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // write_address[14:0], write_data[22:15], zero[23]
    logic        m_tlast;            // run_last
    logic [1:0]  m_tuser;            // picture_done[0], format_error[1]

    // predictor state
    t_parse_st    parse_st    = ST_TYPE;
    int unsigned  hdr_left    = 0;
    bit           packed_mode = 1'b0;
    int unsigned  pending     = 0;
    int unsigned  wptr        = 0;
    bit           odd_step    = 1'b0;
    int unsigned  plane_off   = 0;
    int unsigned  plane_idx   = 0;
    int unsigned  line_idx    = 0;
    bit           fmt_err     = 1'b0;
    pbu_pkg::t_wr expected_writes[$];

    int unsigned  bytes_sent    = 0;
    int           mismatches    = 0;
    bit           quiet_mode    = 1'b0;
    int           hold_request  = 0;
    int           hold_left     = 0;
    int           stall_cycles  = 0;
    pbu_pkg::t_wr want_wr;

    packbits_bitplane_unpacker_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void emit_plane_byte(logic [7:0] value, bit last);
        pbu_pkg::t_wr w;
        w.addr = pbu_pkg::ADDR_W'(wptr);
        w.data = value;
        w.last = last;
        w.done = 1'b0;
        w.err  = fmt_err;
        expected_writes.push_back(w);
        wptr     = (wptr + (odd_step ? 7 : 1)) % pbu_pkg::BITMAP_BYTES;
        odd_step = !odd_step;
    endfunction

    function automatic void mark_done();
        pbu_pkg::t_wr w;
        w = expected_writes.pop_back();
        w.done = 1'b1;
        expected_writes.push_back(w);
    endfunction

    // plane line full: step back into the next plane, or on to the next line
    function automatic bit next_plane_line();
        plane_off = 0;
        wptr = (wptr + pbu_pkg::BITMAP_BYTES - pbu_pkg::BACK_STEP) % pbu_pkg::BITMAP_BYTES;
        if (plane_idx + 1 >= pbu_pkg::PLANES) begin
            plane_idx = 0;
            line_idx  = (line_idx + 1) & 8'hFF;
            wptr      = (wptr + pbu_pkg::FWD_STEP) % pbu_pkg::BITMAP_BYTES;
            return line_idx == pbu_pkg::LINES;
        end
        plane_idx = plane_idx + 1;
        return 1'b0;
    endfunction

    function automatic void predict_writes(logic [7:0] value);
        int unsigned room;
        int unsigned cnt;
        int unsigned k;
        case (parse_st)
            ST_TYPE: begin
                packed_mode = (value == pbu_pkg::TYPE_PACKED);
                hdr_left    = pbu_pkg::HEADER_BYTES;
                parse_st    = ST_SKIP;
            end
            ST_SKIP: begin
                hdr_left = hdr_left - 1;
                if (hdr_left == 0) parse_st = packed_mode ? ST_CTRL : ST_RAW;
            end
            ST_CTRL: begin
                room = pbu_pkg::PLANE_LINE_BYTES - plane_off;
                if (value[7]) begin
                    cnt = 257 - value;
                    // run clipped to the end of the plane line
                    if (cnt > room) begin
                        cnt     = room;
                        fmt_err = 1'b1;
                    end
                    parse_st = ST_RUN;
                end else begin
                    cnt = value + 1;
                    if (cnt > room) fmt_err = 1'b1;
                    parse_st = ST_LIT;
                end
                pending = cnt;
            end
            ST_RUN: begin
                for (k = 0; k < pending; k++) emit_plane_byte(value, k + 1 == pending);
                plane_off = plane_off + pending;
                pending   = 0;
                parse_st  = ST_CTRL;
                if (plane_off >= pbu_pkg::PLANE_LINE_BYTES && next_plane_line()) begin
                    parse_st = ST_DONE;
                    mark_done();
                end
            end
            ST_LIT: begin
                emit_plane_byte(value, 1'b1);
                plane_off = plane_off + 1;
                pending   = (pending - 1) & 8'hFF;
                parse_st  = (pending == 0) ? ST_CTRL : ST_LIT;
                if (plane_off >= pbu_pkg::PLANE_LINE_BYTES) begin
                    if (next_plane_line()) begin
                        parse_st = ST_DONE;
                        mark_done();
                    end else if (pending != 0) begin
                        parse_st = ST_DROP;
                    end
                end
            end
            ST_DROP: begin
                pending = (pending - 1) & 8'hFF;
                if (pending == 0) parse_st = ST_CTRL;
            end
            ST_RAW: begin
                emit_plane_byte(value, 1'b1);
                odd_step = 1'b0;
                // raw copy is sequential, undo the interleaved step
                wptr = (expected_writes[$].addr + 1);
                if (wptr >= pbu_pkg::BITMAP_BYTES) begin
                    parse_st = ST_DONE;
                    mark_done();
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------

    // one request on the input side, called and returning at a falling edge
    task automatic send_byte(input logic [7:0] value);
        while (!quiet_mode && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_writes(value);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input int unsigned count, input logic [7:0] value);
        send_byte(8'(257 - count));
        send_byte(value);
    endtask

    task automatic send_literal(input int unsigned count);
        int unsigned k;
        send_byte(8'(count - 1));
        for (k = 0; k < count; k++) send_byte(8'($urandom_range(0, 255)));
    endtask

    // feeds random bytes until the parser is back at a control byte or the picture is done
    task automatic finish_packet();
        while (parse_st == ST_RUN || parse_st == ST_LIT || parse_st == ST_DROP)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_fitting_packet(input bit favor_full);
        int unsigned room;
        int unsigned cnt;
        room = pbu_pkg::PLANE_LINE_BYTES - plane_off;
        if (favor_full) begin
            cnt = ($urandom_range(0, 3) != 0) ? room : $urandom_range(1, room);
            send_run(cnt, 8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1)) cnt = $urandom_range(1, (room < 4) ? room : 4);
            else cnt = $urandom_range(1, room);
            if ($urandom_range(0, 1)) send_run(cnt, 8'($urandom_range(0, 255)));
            else send_literal(cnt);
        end
    endtask

    task automatic send_crossing_packet();
        int unsigned room;
        room = pbu_pkg::PLANE_LINE_BYTES - plane_off;
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1)) send_byte(8'(257 - $urandom_range(room + 1, 129)));
        else send_byte(8'($urandom_range(room, room + 7)));
        finish_packet();
    endtask

    task automatic test_header();
        send_byte(pbu_pkg::TYPE_PACKED);
        send_byte(8'hFF);       // ignored byte
        send_byte(8'h00);
        send_byte(pbu_pkg::TYPE_PACKED);
        repeat (pbu_pkg::HEADER_BYTES - 3) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_basic_packets();
        send_literal(1);                // control 0x00
        send_run(2, 8'hFF);             // control 0xFF
        send_run(3, 8'h00);
        send_literal(4);
        send_run(pbu_pkg::PLANE_LINE_BYTES - plane_off, 8'hA5);
        send_literal(pbu_pkg::PLANE_LINE_BYTES);
        send_run(pbu_pkg::PLANE_LINE_BYTES, 8'h3C);
        // last plane of the line: forward step to the next line
        send_run(pbu_pkg::PLANE_LINE_BYTES, 8'hC3);
    endtask

    task automatic test_random_packets();
        int unsigned stop_at;
        quiet_mode = 1'b1;
        stop_at = bytes_sent + 15;
        while (bytes_sent < stop_at) send_fitting_packet(1'b0);
        quiet_mode = 1'b0;
        // receiver holds off so the unit backs up into its input
        hold_request = 300;
        stop_at = bytes_sent + 25;
        while (bytes_sent < stop_at) send_fitting_packet(1'b0);
    endtask

    task automatic test_format_errors();
        int unsigned stop_at;
        send_run(129, 8'h5A);           // control 0x80, clipped
        send_run(128, 8'hA5);           // control 0x81, clipped
        send_run(pbu_pkg::PLANE_LINE_BYTES - 3, 8'h81);
        send_literal(6);                // three written, three dropped
        send_literal(128);              // control 0x7F
        stop_at = bytes_sent + 15;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) < 3) send_crossing_packet();
            else send_fitting_packet(1'($urandom_range(0, 1)));
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    initial begin
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= quiet_mode || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: write mismatch, expected none, actual addr 0x%0h data 0x%0h",
                             $time, m_tdata[14:0], m_tdata[22:15]);
            end else begin
                want_wr = expected_writes.pop_front();
                check_field("write_address", want_wr.addr, m_tdata[14:0]);
                check_field("write_data", want_wr.data, m_tdata[22:15]);
                check_field("tdata pad", 0, m_tdata[23]);
                check_field("run_last", want_wr.last, m_tlast);
                check_field("picture_done", want_wr.done, m_tuser[0]);
                check_field("format_error", want_wr.err, m_tuser[1]);
            end
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_header();
        test_basic_packets();
        test_random_packets();
        test_format_errors();
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pbu_pkg.sv
rtl/core/pbu_ptr_unit.sv
rtl/core/pbu_out_reg.sv
rtl/core/packbits_bitplane_unpacker_unit.sv
tb/tb_top.sv
